// File: hw/rtl/skset_pkg.sv
// Shared types and constants for the sorted key set block.
// Holds operation codes, status codes, port widths and the cell control struct.
// No dependencies.
package skset_pkg;

  localparam int IN_KEY_W = 16;
  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_CHANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // Update command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } skset_ctrl_t;

endpackage

// File: hw/rtl/skset_cell.sv
// One entry of the sorted key row: holds a key and its compare flags.
// Depends on skset_pkg for the control struct.
module skset_cell #(
  parameter int KEY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 cmp_en,
  input  logic [KEY_BITS-1:0]  cmp_key,
  input  logic                 valid,
  input  skset_pkg::skset_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0]  ins_key,
  input  logic                 lt_prev,
  input  logic [KEY_BITS-1:0]  key_prev,
  input  logic [KEY_BITS-1:0]  key_next,
  output logic                 lt_o,
  output logic                 eq_o,
  output logic [KEY_BITS-1:0]  key_o
);
  import skset_pkg::*;

  logic                lt_r;
  logic                eq_r;
  logic [KEY_BITS-1:0] key_r;

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt_r <= valid & (key_r < cmp_key);
      eq_r <= valid & (key_r == cmp_key);
    end
    // Cells at or above the lower bound take part in the shift.
    if (ctrl.ins && !lt_r) begin
      key_r <= lt_prev ? ins_key : key_prev;
    end else if (ctrl.rem && !lt_r) begin
      key_r <= key_next;
    end
  end

  assign lt_o  = lt_r;
  assign eq_o  = eq_r;
  assign key_o = key_r;

endmodule

// File: hw/rtl/skset_encode.sv
// Turns the row's less-than flags into the lower-bound position and a hit flag.
// Depends on nothing outside this file.
module skset_encode #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7
) (
  input  logic [CAPACITY-1:0] lt_vec,
  input  logic [CAPACITY-1:0] eq_vec,
  output logic [CNT_W-1:0]    pos,
  output logic                hit
);

  logic [CAPACITY-1:0] bound;

  // The flags form a thermometer; the boundary is where it drops to zero.
  always_comb begin
    bound[0] = ~lt_vec[0];
    for (int i = 1; i < CAPACITY; i++) begin
      bound[i] = lt_vec[i-1] & ~lt_vec[i];
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bound[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
    if (lt_vec[CAPACITY-1]) begin
      pos = pos | CNT_W'(CAPACITY);
    end
  end

  assign hit = |eq_vec;

endmodule

// File: hw/rtl/sorted_key_set_top.sv
// Sorted key set: a row of compare-and-shift cells holding distinct keys in order.
// The result strobe is high in the cycle right after the update cycle.
// The cells compare at the accepting edge and shift at the next edge, and busy is
// high for that one update cycle; no new item is taken while busy is high.
// Reset clears the stored count and the control state; key storage is not cleared.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module sorted_key_set_top #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [skset_pkg::OP_W-1:0]      in_op,
  input  logic [skset_pkg::IN_KEY_W-1:0]  in_key,
  output logic                            out_strobe,
  output logic [skset_pkg::POS_W-1:0]     out_position,
  output logic                            out_found,
  output logic [skset_pkg::POS_W-1:0]     out_count,
  output logic [skset_pkg::STAT_W-1:0]    out_status
);
  import skset_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  state_t              state_r;
  logic [OP_W-1:0]     op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;

  logic                out_strobe_r;
  logic [POS_W-1:0]    out_position_r;
  logic                out_found_r;
  logic [POS_W-1:0]    out_count_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [STAT_W-1:0]   status_nxt;

  logic                accept;
  logic [KEY_BITS-1:0] cmp_key;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [KEY_BITS-1:0] key_q [CAPACITY];
  logic [CNT_W-1:0]    pos;
  logic                hit;
  logic                full;
  skset_ctrl_t         ctrl;

  assign accept = start & (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // The incoming key is cut or zero-extended to the stored key width.
  generate
    if (KEY_BITS <= IN_KEY_W) begin : g_key_cut
      assign cmp_key = in_key[KEY_BITS-1:0];
    end else begin : g_key_ext
      assign cmp_key = {{(KEY_BITS - IN_KEY_W){1'b0}}, in_key};
    end
  endgenerate

  // Each cell compares its key with the incoming key on the accepting edge and, in the
  // update cycle that follows, shifts toward or away from its neighbor as the operation asks.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_row
      logic                lt_prev;
      logic [KEY_BITS-1:0] key_prev;
      logic [KEY_BITS-1:0] key_next;

      if (i == 0) begin : g_first
        assign lt_prev  = 1'b1;
        assign key_prev = key_r;
      end else begin : g_mid
        assign lt_prev  = lt_vec[i-1];
        assign key_prev = key_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign key_next = key_q[i];
      end else begin : g_inner
        assign key_next = key_q[i+1];
      end

      skset_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk      (clk),
        .cmp_en   (accept),
        .cmp_key  (cmp_key),
        .valid    (CNT_W'(i) < count_r),
        .ctrl     (ctrl),
        .ins_key  (key_r),
        .lt_prev  (lt_prev),
        .key_prev (key_prev),
        .key_next (key_next),
        .lt_o     (lt_vec[i]),
        .eq_o     (eq_vec[i]),
        .key_o    (key_q[i])
      );
    end
  endgenerate

  skset_encode #(
    .CAPACITY(CAPACITY),
    .CNT_W   (CNT_W)
  ) u_encode (
    .lt_vec (lt_vec),
    .eq_vec (eq_vec),
    .pos    (pos),
    .hit    (hit)
  );

  assign full = (count_r == CNT_W'(CAPACITY));

  // Decide the operation's effect in the update cycle. An unused code acts as find.
  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = STAT_DONE;
    if (state_r == ST_UPD) begin
      case (op_r)
        OP_INSERT: begin
          if (hit) begin
            status_nxt = STAT_NO_CHANGE;
          end else if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            ctrl.rem  = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = STAT_NO_CHANGE;
          end
        end
        default: begin
          status_nxt = STAT_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_r      <= ST_IDLE;
          count_r      <= count_nxt;
          out_strobe_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (accept) begin
      op_r  <= in_op;
      key_r <= cmp_key;
    end
    if (state_r == ST_UPD) begin
      out_position_r <= POS_W'(pos);
      out_found_r    <= hit;
      out_count_r    <= POS_W'(count_nxt);
      out_status_r   <= status_nxt;
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_position = out_position_r;
  assign out_found    = out_found_r;
  assign out_count    = out_count_r;
  assign out_status   = out_status_r;

endmodule

// File: hw/rtl/skset_chk.sv
// Port-level checker for the sorted key set, bound to the top level.
// Depends on skset_pkg for widths and status codes.
module skset_chk #(
  parameter int CAPACITY = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input logic [skset_pkg::POS_W-1:0]     out_position,
  input logic                            out_found,
  input logic [skset_pkg::POS_W-1:0]     out_count,
  input logic [skset_pkg::STAT_W-1:0]    out_status
);
  import skset_pkg::*;

  // Every accepted beat is followed by an update cycle with busy high and no strobe, then by a result strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && out_strobe == 1'b0) ##1 out_strobe)
    else $error("result beat did not follow accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without an item in work");

  // A rejected insert never reports a hit and leaves the store full.
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == STAT_FULL) |->
      (!out_found && out_count == POS_W'(CAPACITY)))
    else $error("store-full result is inconsistent");

  // A position without a hit never lies beyond the count reported in the same reply, unless the status is no-change.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != STAT_NO_CHANGE && !out_found) |->
      (out_position <= out_count))
    else $error("position beyond stored count");

endmodule

bind sorted_key_set_top skset_chk #(.CAPACITY(CAPACITY)) u_skset_chk (.*);

// File: tb/tb_top.sv
// Self-checking bench for the sorted key set: insert, remove and find on a 64-entry store.
// Predicts every reply with its own copy of the ordered key list and compares it field by field.
// Depends on skset_pkg and sorted_key_set_top.
`timescale 1ns / 1ps

module tb_top;
  import skset_pkg::*;

  localparam int SET_CAPACITY = 64;
  localparam int KEY_W        = 16;
  // Limit on consecutive cycles in which neither an item nor a reply is accepted.
  localparam int STALL_LIMIT  = 1000;
  // The package names three operations; the fourth code must act like a find.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One reply beat as it appears on the out_ ports.
  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              found;
    logic [POS_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } set_reply_t;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                start    = 1'b0;
  logic [OP_W-1:0]     in_op    = OP_FIND;
  logic [IN_KEY_W-1:0] in_key   = '0;
  logic                busy;
  logic                out_strobe;
  logic [POS_W-1:0]    out_position;
  logic                out_found;
  logic [POS_W-1:0]    out_count;
  logic [STAT_W-1:0]   out_status;

  // Shadow of the block's store: ascending distinct keys, valid below model_count.
  logic [KEY_W-1:0] model_keys [SET_CAPACITY];
  int               model_count = 0;

  // Replies predicted at each accepted item, oldest first.
  set_reply_t predicted_replies [$];
  int         mismatch_count = 0;
  int         idle_cycles    = 0;
  // Items left in the current sender burst before the next gap.
  int         burst_left     = 0;

  always #2 clk = ~clk;

  sorted_key_set_top #(
    .CAPACITY(SET_CAPACITY),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_key      (in_key),
    .out_strobe  (out_strobe),
    .out_position(out_position),
    .out_found   (out_found),
    .out_count   (out_count),
    .out_status  (out_status)
  );

  // Index of the first stored key that is not less than k; equals the count if none.
  function automatic int lower_bound_of(logic [KEY_W-1:0] k);
    int i;
    i = 0;
    while (i < model_count && model_keys[i] < k) i++;
    return i;
  endfunction

  function automatic bit key_is_stored(logic [KEY_W-1:0] k);
    int p;
    p = lower_bound_of(k);
    return (p < model_count) && (model_keys[p] == k);
  endfunction

  // Applies one operation to the shadow store and returns the reply it must produce.
  // The position and the found flag are taken before the store changes.
  function automatic set_reply_t apply_set_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
    set_reply_t r;
    int         p;
    bit         hit;
    p   = lower_bound_of(k);
    hit = (p < model_count) && (model_keys[p] == k);
    r.status = STAT_DONE;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          r.status = STAT_NO_CHANGE;
        end else if (model_count >= SET_CAPACITY) begin
          // A new key into a full store is turned away and nothing moves.
          r.status = STAT_FULL;
        end else begin
          for (int i = model_count; i > p; i--) model_keys[i] = model_keys[i-1];
          model_keys[p] = k;
          model_count++;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (int i = p; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
          model_count--;
        end else begin
          r.status = STAT_NO_CHANGE;
        end
      end
      // Find and the unused code only report the lower bound.
      default: r.status = STAT_DONE;
    endcase
    r.position = p[POS_W-1:0];
    r.found    = hit;
    r.count    = model_count[POS_W-1:0];
    return r;
  endfunction

  // Presents one item, holds it until the block takes it, records the predicted
  // reply, and then either keeps start high for the next beat of the burst or
  // drops it for a random gap.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    start  <= 1'b1;
    in_op  <= op;
    in_key <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted_replies.push_back(apply_set_op(op, k));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      // Bursts of zero make every item stand alone; long ones keep start high.
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  endtask

  // Draws a key: a stored one when asked and available, otherwise from a small
  // range (many collisions), a medium range, the whole range, or the extremes.
  function automatic logic [KEY_W-1:0] pick_key(bit prefer_stored);
    logic [KEY_W-1:0] k;
    if (prefer_stored && model_count > 0) begin
      k = model_keys[$urandom_range(0, model_count - 1)];
    end else begin
      case ($urandom_range(0, 3))
        0:       k = KEY_W'($urandom_range(0, 63));
        1:       k = KEY_W'($urandom_range(0, 1023));
        2:       k = KEY_W'($urandom_range(0, 65535));
        default: begin
          case ($urandom_range(0, 3))
            0:       k = '0;
            1:       k = 16'd1;
            2:       k = 16'hFFFE;
            default: k = 16'hFFFF;
          endcase
        end
      endcase
    end
    return k;
  endfunction

  // Empty store, the key extremes, every operation, duplicates, absent removes,
  // and removal from the front, the middle and the back.
  task automatic test_directed;
    send_item(OP_FIND,   16'd0);
    send_item(OP_REMOVE, 16'd5);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_INSERT, 16'd1000);
    send_item(OP_INSERT, 16'd1000);
    send_item(OP_INSERT, 16'd0);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'd500);
    send_item(OP_INSERT, 16'hAAAA);
    send_item(OP_INSERT, 16'h5555);
    send_item(OP_FIND,   16'hFFFF);
    send_item(OP_FIND,   16'd700);
    send_item(OP_FIND,   16'hFFFE);
    send_item(OP_UNUSED, 16'd0);
    send_item(OP_REMOVE, 16'd500);
    send_item(OP_REMOVE, 16'd500);
    send_item(OP_REMOVE, 16'd0);
    send_item(OP_REMOVE, 16'hFFFF);
    send_item(OP_REMOVE, 16'hAAAA);
    send_item(OP_REMOVE, 16'h5555);
    send_item(OP_REMOVE, 16'd1000);
    send_item(OP_FIND,   16'd1000);
  endtask

  // Fills the store to capacity with random keys, then hits it with new keys,
  // duplicates and lookups past the last entry while it is full.
  task automatic test_capacity_limits;
    logic [KEY_W-1:0] k;
    while (model_count < SET_CAPACITY) send_item(OP_INSERT, pick_key(1'b0));
    repeat (4) begin
      k = pick_key(1'b0);
      while (key_is_stored(k)) k = KEY_W'($urandom_range(0, 65535));
      send_item(OP_INSERT, k);
    end
    if (!key_is_stored(16'hFFFF)) send_item(OP_INSERT, 16'hFFFF);
    if (!key_is_stored(16'h0000)) send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, pick_key(1'b1));
    send_item(OP_INSERT, model_keys[SET_CAPACITY-1]);
    send_item(OP_FIND,   16'hFFFF);
    send_item(OP_UNUSED, model_keys[0]);
    // Free one entry and take it again, so a full store can still accept.
    k = pick_key(1'b1);
    send_item(OP_REMOVE, k);
    send_item(OP_INSERT, k);
  endtask

  // Mostly episodes that grow the store to full and shrink it back, with
  // random content; a small share of items are arbitrary operations and keys.
  task automatic test_random_mix(input int n_items);
    bit growing;
    int shrink_floor;
    int linger;
    int r;
    growing      = (model_count < SET_CAPACITY);
    shrink_floor = 0;
    linger       = $urandom_range(2, 8);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(OP_W'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 65535)));
      end else if (growing) begin
        if (r < 65)      send_item(OP_INSERT, pick_key($urandom_range(0, 4) == 0));
        else if (r < 78) send_item(OP_REMOVE, pick_key($urandom_range(0, 1) != 0));
        else if (r < 95) send_item(OP_FIND,   pick_key($urandom_range(0, 1) != 0) + KEY_W'(1));
        else             send_item(OP_UNUSED, pick_key(1'b1));
      end else begin
        if (r < 22)      send_item(OP_INSERT, pick_key($urandom_range(0, 1) != 0));
        else if (r < 75) send_item(OP_REMOVE, pick_key($urandom_range(0, 3) != 0));
        else if (r < 95) send_item(OP_FIND,   pick_key($urandom_range(0, 1) != 0) - KEY_W'(1));
        else             send_item(OP_UNUSED, pick_key(1'b0));
      end
      // Stay at the full end or at the shrink floor a few items before turning around.
      if (growing && model_count == SET_CAPACITY) begin
        if (linger > 0) begin
          linger--;
        end else begin
          growing      = 1'b0;
          shrink_floor = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
          linger       = $urandom_range(2, 8);
        end
      end else if (!growing && model_count <= shrink_floor) begin
        if (linger > 0) begin
          linger--;
        end else begin
          growing = 1'b1;
          linger  = $urandom_range(2, 8);
        end
      end
    end
  endtask

  // Compares each reply beat with the oldest prediction. The block cannot be
  // held off, so every strobe is a beat that must be checked in that cycle.
  always @(posedge clk) begin : reply_check
    set_reply_t want;
    if (rst_n && out_strobe) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: reply with none expected: position %0d found %0d count %0d status %0d",
                 $time, out_position, out_found, out_count, out_status);
        mismatch_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (out_position !== want.position) begin
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, want.position, out_position);
          mismatch_count++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $time, want.found, out_found);
          mismatch_count++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, want.count, out_count);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any accepted item or reply beat counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // Synchronous reset held low from the start, released once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed;
    test_capacity_limits;
    test_random_mix(1100);
    start <= 1'b0;
    // Drain the outstanding replies, then watch a few more cycles for strays.
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/skset_pkg.sv
hw/rtl/skset_cell.sv
hw/rtl/skset_encode.sv
hw/rtl/sorted_key_set_top.sv
hw/rtl/skset_chk.sv
tb/tb_top.sv
